/* hdl/ccs_pkg.sv */
package ccs_pkg;

  localparam int LINE_BITS    = 20;
  localparam int BALANCE_BITS = 16;
  localparam int CHAR_W       = 21;
  localparam int ELINE_W      = 20;

  localparam logic [CHAR_W-1:0] CH_QUOTE = CHAR_W'(8'h22);
  localparam logic [CHAR_W-1:0] CH_SLASH = CHAR_W'(8'h2F);
  localparam logic [CHAR_W-1:0] CH_STAR  = CHAR_W'(8'h2A);
  localparam logic [CHAR_W-1:0] CH_NL    = CHAR_W'(8'h0A);

  localparam logic [LINE_BITS-1:0] LINE_MAX = {LINE_BITS{1'b1}};
  localparam logic signed [BALANCE_BITS-1:0] BAL_MAX = {1'b0, {(BALANCE_BITS-1){1'b1}}};
  localparam logic signed [BALANCE_BITS-1:0] BAL_MIN = {1'b1, {(BALANCE_BITS-1){1'b0}}};

  typedef enum logic [6:0] {
    MODE_NORMAL = 7'b0000001,
    MODE_STRING = 7'b0000010,
    MODE_SLASH  = 7'b0000100,
    MODE_STAR   = 7'b0001000,
    MODE_LINE   = 7'b0010000,
    MODE_BLOCK  = 7'b0100000,
    MODE_BSTAR  = 7'b1000000
  } ccs_mode_t;

  typedef struct packed {
    logic [CHAR_W-1:0]  out_char;
    logic               char_valid;
    logic               is_last;
    logic               at_end;
    logic               mismatch;
    logic [ELINE_W-1:0] fault_line;
  } ccs_res_t;

  typedef struct packed {
    logic [1:0] num;
    ccs_res_t   r0;
    ccs_res_t   r1;
  } ccs_push_t;

  function automatic ccs_res_t ccs_char_res(input logic [CHAR_W-1:0] c);
    ccs_res_t r;
    r            = '0;
    r.out_char   = c;
    r.char_valid = 1'b1;
    return r;
  endfunction

endpackage

/* hdl/ccs_scan.sv */
module ccs_scan (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      item_vld,
  input  logic                      item_action,
  input  logic [ccs_pkg::CHAR_W-1:0] item_char,
  input  logic [1:0]                fifo_free,
  output logic                      take,
  output ccs_pkg::ccs_push_t        push
);
  import ccs_pkg::*;

  ccs_mode_t                       mode_r, mode_nxt;
  logic [LINE_BITS-1:0]            line_r, line_nxt;
  logic signed [BALANCE_BITS-1:0]  bal_r, bal_nxt;
  logic [LINE_BITS-1:0]            mark_r, mark_nxt;

  logic              emit0, emit1, stat;
  logic [CHAR_W-1:0] ch0, ch1;
  logic              bump, up, down;
  logic [1:0]        num;
  ccs_res_t          res1, st_res;

  always_comb begin
    emit0    = 1'b0;
    emit1    = 1'b0;
    stat     = 1'b0;
    ch0      = '0;
    ch1      = item_char;
    bump     = 1'b0;
    up       = 1'b0;
    down     = 1'b0;
    mode_nxt = mode_r;
    mark_nxt = mark_r;
    if (item_action) begin
      stat     = 1'b1;
      emit1    = 1'b1;
      mode_nxt = MODE_NORMAL;
      if (mode_r == MODE_SLASH) begin
        emit0 = 1'b1;
        ch0   = CH_SLASH;
      end else if (mode_r == MODE_STAR) begin
        emit0 = 1'b1;
        ch0   = CH_STAR;
      end
    end else begin
      unique case (mode_r) inside
        MODE_STRING: begin
          emit1 = 1'b1;
          if (item_char == CH_QUOTE) begin
            mode_nxt = MODE_NORMAL;
          end else if (item_char == CH_NL) begin
            bump = 1'b1;
          end
        end
        MODE_SLASH, MODE_STAR: begin
          if (mode_r == MODE_SLASH && item_char == CH_SLASH) begin
            mode_nxt = MODE_LINE;
          end else if (mode_r == MODE_SLASH && item_char == CH_STAR) begin
            mark_nxt = line_r;
            up       = 1'b1;
            mode_nxt = MODE_BLOCK;
          end else if (mode_r == MODE_STAR && item_char == CH_SLASH) begin
            mark_nxt = line_r;
            down     = 1'b1;
            mode_nxt = MODE_SLASH;
          end else begin
            emit0 = 1'b1;
            ch0   = (mode_r == MODE_SLASH) ? CH_SLASH : CH_STAR;
            if (item_char == CH_QUOTE) begin
              emit1    = 1'b1;
              mode_nxt = MODE_STRING;
            end else if (item_char == CH_SLASH) begin
              mode_nxt = MODE_SLASH;
            end else if (item_char == CH_STAR) begin
              mode_nxt = MODE_STAR;
            end else begin
              emit1    = 1'b1;
              bump     = (item_char == CH_NL);
              mode_nxt = MODE_NORMAL;
            end
          end
        end
        MODE_LINE: begin
          if (item_char == CH_NL) begin
            bump     = 1'b1;
            emit1    = 1'b1;
            mode_nxt = MODE_NORMAL;
          end
        end
        MODE_BLOCK: begin
          if (item_char == CH_NL) begin
            bump  = 1'b1;
            emit1 = 1'b1;
          end else if (item_char == CH_STAR) begin
            mode_nxt = MODE_BSTAR;
          end
        end
        MODE_BSTAR: begin
          if (item_char == CH_SLASH) begin
            down     = 1'b1;
            mode_nxt = MODE_NORMAL;
          end else if (item_char != CH_STAR) begin
            mode_nxt = MODE_BLOCK;
            if (item_char == CH_NL) begin
              bump  = 1'b1;
              emit1 = 1'b1;
            end
          end
        end
        default: begin
          if (item_char == CH_QUOTE) begin
            emit1    = 1'b1;
            mode_nxt = MODE_STRING;
          end else if (item_char == CH_SLASH) begin
            mode_nxt = MODE_SLASH;
          end else if (item_char == CH_STAR) begin
            mode_nxt = MODE_STAR;
          end else begin
            emit1    = 1'b1;
            bump     = (item_char == CH_NL);
            mode_nxt = MODE_NORMAL;
          end
        end
      endcase
    end
  end

  always_comb begin
    line_nxt = line_r;
    bal_nxt  = bal_r;
    if (bump && line_r != LINE_MAX) begin
      line_nxt = line_r + 1'b1;
    end
    if (up && bal_r != BAL_MAX) begin
      bal_nxt = bal_r + BALANCE_BITS'(1);
    end else if (down && bal_r != BAL_MIN) begin
      bal_nxt = bal_r - BALANCE_BITS'(1);
    end
  end

  always_comb begin
    st_res            = '0;
    st_res.is_last    = 1'b1;
    st_res.at_end     = 1'b1;
    st_res.mismatch   = (bal_r != '0);
    st_res.fault_line = st_res.mismatch ? ELINE_W'(mark_r) : '0;
    res1              = stat ? st_res : ccs_char_res(ch1);
    res1.is_last      = 1'b1;
    num               = {1'b0, emit0} + {1'b0, emit1};
    take              = item_vld && (num <= fifo_free);
    push.num          = take ? num : 2'd0;
    push.r1           = res1;
    if (emit0) begin
      push.r0         = ccs_char_res(ch0);
      push.r0.is_last = !emit1;
    end else begin
      push.r0 = res1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_NORMAL;
      line_r <= '0;
      bal_r  <= '0;
      mark_r <= '0;
    end else if (take) begin
      if (item_action) begin
        mode_r <= MODE_NORMAL;
        line_r <= '0;
        bal_r  <= '0;
        mark_r <= '0;
      end else begin
        mode_r <= mode_nxt;
        line_r <= line_nxt;
        bal_r  <= bal_nxt;
        mark_r <= mark_nxt;
      end
    end
  end

endmodule

/* hdl/ccs_out_fifo.sv */
module ccs_out_fifo (
  input  logic               clk,
  input  logic               rst_n,
  input  ccs_pkg::ccs_push_t push,
  output logic [1:0]         fifo_free,
  output logic               head_vld,
  input  logic               head_rdy,
  output ccs_pkg::ccs_res_t  head
);
  import ccs_pkg::*;

  ccs_res_t   q0_r, q1_r, q0_nxt, q1_nxt, rem0;
  logic [1:0] cnt_r, cnt_nxt, rem;
  logic       pop;

  assign head_vld  = (cnt_r != 2'd0);
  assign head      = q0_r;
  assign fifo_free = 2'd2 - cnt_r;
  assign pop       = head_vld && head_rdy;

  always_comb begin
    rem     = cnt_r - {1'b0, pop};
    rem0    = pop ? q1_r : q0_r;
    q0_nxt  = q0_r;
    q1_nxt  = q1_r;
    cnt_nxt = rem + push.num;
    if (rem == 2'd0) begin
      q0_nxt = push.r0;
      q1_nxt = push.r1;
    end else begin
      q0_nxt = rem0;
      if (push.num != 2'd0) begin
        q1_nxt = push.r0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q0_r <= q0_nxt;
    q1_r <= q1_nxt;
  end

endmodule

/* hdl/c_comment_stripper.sv */
// Streaming C comment remover. One character or end-of-text item is taken per
// cycle into an input register, scanned against the current mode and queued
// as up to two results in a two-entry output queue that feeds out_*. An item
// passes through the input register and then the output queue before any of
// its results appears. With the output side always ready, throughput is one
// item per cycle; an item that releases a held slash or star together with
// its own character needs both queue entries, so it waits for the queue to
// empty and then holds off the next item until one of its results has left;
// a full queue holds off input.
module c_comment_stripper (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_action,
  input  logic [ccs_pkg::CHAR_W-1:0]  in_char_in,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [ccs_pkg::CHAR_W-1:0]  out_char,
  output logic                        out_char_valid,
  output logic                        out_is_last,
  output logic                        out_at_end,
  output logic                        out_mismatch,
  output logic [ccs_pkg::ELINE_W-1:0] out_fault_line
);
  import ccs_pkg::*;

  logic              in_vld_r, in_vld_nxt;
  logic              in_action_r;
  logic [CHAR_W-1:0] in_char_r;
  logic              take;
  logic [1:0]        fifo_free;
  ccs_push_t         push;
  ccs_res_t          head;

  assign in_ready = !in_vld_r || take;

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (in_valid && in_ready) begin
      in_vld_nxt = 1'b1;
    end else if (take) begin
      in_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= in_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_action_r <= in_action;
      in_char_r   <= in_char_in;
    end
  end

  ccs_scan u_scan (
    .clk         (clk),
    .rst_n       (rst_n),
    .item_vld    (in_vld_r),
    .item_action (in_action_r),
    .item_char   (in_char_r),
    .fifo_free   (fifo_free),
    .take        (take),
    .push        (push)
  );

  ccs_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .fifo_free (fifo_free),
    .head_vld  (out_valid),
    .head_rdy  (out_ready),
    .head      (head)
  );

  assign out_char       = head.out_char;
  assign out_char_valid = head.char_valid;
  assign out_is_last    = head.is_last;
  assign out_at_end     = head.at_end;
  assign out_mismatch   = head.mismatch;
  assign out_fault_line = head.fault_line;

endmodule

/* hdl/ccs_checker.sv */
module ccs_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [ccs_pkg::CHAR_W-1:0]  out_char,
  input logic                        out_char_valid,
  input logic                        out_is_last,
  input logic                        out_at_end,
  input logic                        out_mismatch,
  input logic [ccs_pkg::ELINE_W-1:0] out_fault_line
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_char) && $stable(out_at_end))
    else $error("stalled result changed");

  a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_at_end |-> out_is_last && !out_char_valid && out_char == '0)
    else $error("status result malformed");

  a_char_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_char_valid |-> !out_at_end && !out_mismatch && out_fault_line == '0)
    else $error("character result carries status");

  a_err_line: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_mismatch |-> out_fault_line == '0)
    else $error("error line without mismatch");

  a_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_char_valid || out_at_end)
    else $error("empty result");

endmodule

bind c_comment_stripper ccs_checker u_ccs_checker (.*);

/* dv/c_comment_stripper_test.sv */
`timescale 1ns / 100ps

module c_comment_stripper_test;
  import ccs_pkg::*;

  localparam logic ACT_CHAR = 1'b0;
  localparam logic ACT_END  = 1'b1;

  localparam int CYCLE_LIMIT  = 3_000_000;
  localparam int HOLD_CYCLES  = 300;
  localparam int RAND_ITEMS   = 1050;
  localparam int STRAY_CLOSES = 30;
  localparam int DRAIN_CYCLES = 20;

  typedef struct packed {
    logic              action;
    logic [CHAR_W-1:0] code;
  } text_item_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic                in_action = ACT_CHAR;
  logic [CHAR_W-1:0]   in_char_in = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [CHAR_W-1:0]   out_char;
  logic                out_char_valid;
  logic                out_is_last;
  logic                out_at_end;
  logic                out_mismatch;
  logic [ELINE_W-1:0]  out_fault_line;

  c_comment_stripper dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_action      (in_action),
    .in_char_in     (in_char_in),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_char       (out_char),
    .out_char_valid (out_char_valid),
    .out_is_last    (out_is_last),
    .out_at_end     (out_at_end),
    .out_mismatch   (out_mismatch),
    .out_fault_line (out_fault_line)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  text_item_t pending_text[$];
  ccs_res_t   stripped_q[$];

  ccs_mode_t                       scan_mode = MODE_NORMAL;
  logic [LINE_BITS-1:0]            line_no = '0;
  logic signed [BALANCE_BITS-1:0]  nest_bal = '0;
  logic [LINE_BITS-1:0]            mark_no = '0;
  ccs_res_t                        step_res[2];
  int                              step_n;

  int  items_queued = 0;
  int  items_taken = 0;
  int  results_seen = 0;
  int  end_reports = 0;
  int  fails = 0;
  int  cycle_no = 0;
  int  send_gap = 0;
  int  stall_left = 0;
  int  hold_left = 0;
  bit  hold_done = 1'b0;
  bit  hold_req = 1'b0;
  bit  idle_on = 1'b1;
  text_item_t next_text;
  ccs_res_t   want;

  task automatic clear_scan();
    scan_mode = MODE_NORMAL;
    line_no   = '0;
    nest_bal  = '0;
    mark_no   = '0;
  endtask

  task automatic put_text(input logic [CHAR_W-1:0] c);
    ccs_res_t r;
    r                 = '0;
    r.out_char        = c;
    r.char_valid      = 1'b1;
    step_res[step_n]  = r;
    step_n++;
  endtask

  task automatic add_line();
    if (line_no != LINE_MAX) line_no = line_no + 1'b1;
  endtask

  task automatic drop_bal();
    if (nest_bal != BAL_MIN) nest_bal = nest_bal - BALANCE_BITS'(1);
  endtask

  task automatic plain_char(input logic [CHAR_W-1:0] c);
    if (c == CH_QUOTE) begin
      put_text(c);
      scan_mode = MODE_STRING;
    end else if (c == CH_SLASH) begin
      scan_mode = MODE_SLASH;
    end else if (c == CH_STAR) begin
      scan_mode = MODE_STAR;
    end else begin
      if (c == CH_NL) add_line();
      put_text(c);
      scan_mode = MODE_NORMAL;
    end
  endtask

  task automatic strip_step(input logic act, input logic [CHAR_W-1:0] c);
    ccs_res_t status;
    step_n = 0;
    if (act == ACT_END) begin
      if (scan_mode == MODE_SLASH) put_text(CH_SLASH);
      else if (scan_mode == MODE_STAR) put_text(CH_STAR);
      status        = '0;
      status.at_end = 1'b1;
      if (nest_bal != 0) begin
        status.mismatch   = 1'b1;
        status.fault_line = ELINE_W'(mark_no);
      end
      step_res[step_n] = status;
      step_n++;
      clear_scan();
    end else begin
      case (scan_mode)
        MODE_STRING: begin
          if (c == CH_QUOTE) scan_mode = MODE_NORMAL;
          else if (c == CH_NL) add_line();
          put_text(c);
        end
        MODE_SLASH: begin
          if (c == CH_SLASH) begin
            scan_mode = MODE_LINE;
          end else if (c == CH_STAR) begin
            mark_no = line_no;
            if (nest_bal != BAL_MAX) nest_bal = nest_bal + BALANCE_BITS'(1);
            scan_mode = MODE_BLOCK;
          end else begin
            put_text(CH_SLASH);
            plain_char(c);
          end
        end
        MODE_STAR: begin
          if (c == CH_SLASH) begin
            mark_no = line_no;
            drop_bal();
            scan_mode = MODE_SLASH;
          end else begin
            put_text(CH_STAR);
            plain_char(c);
          end
        end
        MODE_LINE: begin
          if (c == CH_NL) begin
            add_line();
            put_text(c);
            scan_mode = MODE_NORMAL;
          end
        end
        MODE_BLOCK: begin
          if (c == CH_NL) begin
            add_line();
            put_text(c);
          end else if (c == CH_STAR) begin
            scan_mode = MODE_BSTAR;
          end
        end
        MODE_BSTAR: begin
          if (c == CH_SLASH) begin
            drop_bal();
            scan_mode = MODE_NORMAL;
          end else if (c != CH_STAR) begin
            if (c == CH_NL) begin
              add_line();
              put_text(c);
            end
            scan_mode = MODE_BLOCK;
          end
        end
        default: plain_char(c);
      endcase
    end
    if (step_n > 0) step_res[step_n-1].is_last = 1'b1;
    for (int i = 0; i < step_n; i++) stripped_q.insert(stripped_q.size(), step_res[i]);
  endtask

  task automatic report_miss(input string what, input logic [31:0] got,
                             input logic [31:0] exp_val);
    if (fails < 40)
      $display("%0t: %s differs, got %0h, wanted %0h", $time, what, got, exp_val);
    fails++;
  endtask

  // sender: hold each transfer until taken
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid   <= 1'b0;
      in_action  <= ACT_CHAR;
      in_char_in <= '0;
      send_gap   <= 0;
      clear_scan();
    end else begin
      if (in_valid && in_ready) begin
        strip_step(in_action, in_char_in);
        items_taken <= items_taken + 1;
      end
      if (in_valid && !in_ready) begin
        in_valid <= 1'b1;
      end else if (send_gap != 0) begin
        in_valid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (pending_text.size() != 0) begin
        next_text  = pending_text.pop_front();
        in_valid   <= 1'b1;
        in_action  <= next_text.action;
        in_char_in <= next_text.code;
        if (idle_on && $urandom_range(0, 7) == 0) send_gap <= $urandom_range(1, 9);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: check each transfer against the oldest expectation
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen <= results_seen + 1;
        if (out_at_end) end_reports <= end_reports + 1;
        if (stripped_q.size() == 0) begin
          report_miss("unexpected result", 32'(out_char), '0);
        end else begin
          want = stripped_q.pop_front();
          if (out_char !== want.out_char)
            report_miss("out_char", 32'(out_char), 32'(want.out_char));
          if (out_char_valid !== want.char_valid)
            report_miss("out_char_valid", 32'(out_char_valid), 32'(want.char_valid));
          if (out_is_last !== want.is_last)
            report_miss("out_is_last", 32'(out_is_last), 32'(want.is_last));
          if (out_at_end !== want.at_end)
            report_miss("out_at_end", 32'(out_at_end), 32'(want.at_end));
          if (out_mismatch !== want.mismatch)
            report_miss("out_mismatch", 32'(out_mismatch), 32'(want.mismatch));
          if (out_fault_line !== want.fault_line)
            report_miss("out_fault_line", 32'(out_fault_line), 32'(want.fault_line));
        end
      end
      if (hold_left != 0) begin
        out_ready <= 1'b0;
      end else if (stall_left != 0) begin
        out_ready  <= 1'b0;
        stall_left <= stall_left - 1;
      end else begin
        out_ready <= 1'b1;
        if (idle_on && $urandom_range(0, 7) == 0) stall_left <= $urandom_range(1, 9);
      end
    end
  end

  // long output hold-off, started once on request
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycle_no <= cycle_no + 1;
    if (cycle_no == CYCLE_LIMIT) begin
      $display("run stopped at the cycle limit");
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic queue_char(input logic [CHAR_W-1:0] c);
    text_item_t t;
    t.action = ACT_CHAR;
    t.code   = c;
    pending_text.insert(pending_text.size(), t);
    items_queued++;
  endtask

  task automatic queue_end();
    text_item_t t;
    t.action = ACT_END;
    t.code   = CHAR_W'($urandom_range(0, 21'h1FFFFF));
    pending_text.insert(pending_text.size(), t);
    items_queued++;
  endtask

  task automatic queue_str(input string s);
    for (int i = 0; i < s.len(); i++) queue_char(CHAR_W'(s[i]));
  endtask

  function automatic logic [CHAR_W-1:0] pick_text();
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) return CHAR_W'($urandom_range(8'h61, 8'h7A));
    if (r == 7) return CHAR_W'(8'h20);
    if (r == 8) return CH_NL;
    return CHAR_W'($urandom_range(0, 21'h1FFFFF));
  endfunction

  function automatic logic [CHAR_W-1:0] pick_body();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return CH_SLASH;
    if (r == 1) return CH_STAR;
    if (r == 2) return CH_NL;
    return pick_text();
  endfunction

  function automatic logic [CHAR_W-1:0] pick_noise();
    int r;
    r = $urandom_range(0, 4);
    if (r == 0) return CH_QUOTE;
    if (r == 1) return CH_SLASH;
    if (r == 2) return CH_STAR;
    if (r == 3) return CH_NL;
    return CHAR_W'($urandom_range(0, 21'h1FFFFF));
  endfunction

  task automatic queue_fragment();
    int kind;
    int n;
    kind = $urandom_range(0, 99);
    n    = $urandom_range(0, 6);
    if (kind < 30) begin
      repeat (n + 1) queue_char(pick_text());
    end else if (kind < 44) begin
      queue_char(CH_QUOTE);
      repeat (n) queue_char(pick_body());
      if ($urandom_range(0, 9) != 0) queue_char(CH_QUOTE);
    end else if (kind < 56) begin
      queue_char(CH_SLASH);
      queue_char(CH_SLASH);
      repeat (n) queue_char(pick_body());
      queue_char(CH_NL);
    end else if (kind < 74) begin
      queue_char(CH_SLASH);
      queue_char(CH_STAR);
      repeat (n) queue_char(pick_body());
      if ($urandom_range(0, 7) != 0) begin
        if ($urandom_range(0, 3) == 0) queue_char(CH_STAR);
        queue_char(CH_STAR);
        queue_char(CH_SLASH);
      end
    end else if (kind < 82) begin
      queue_char(CH_STAR);
      queue_char(CH_SLASH);
    end else if (kind < 89) begin
      queue_char($urandom_range(0, 1) ? CH_SLASH : CH_STAR);
      queue_char(pick_text());
    end else if (kind < 97) begin
      repeat (n + 1) queue_char(pick_noise());
    end else begin
      queue_end();
    end
  endtask

  task automatic wait_drained();
    while (items_taken != items_queued) @(posedge clk);
    while (stripped_q.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    int target;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    queue_char('0);
    queue_char({CHAR_W{1'b1}});
    queue_str("\"/*\"");
    queue_str("//x\n");
    queue_str("*/a");
    queue_str("/*\n**/");
    queue_str("/");
    queue_end();
    queue_str("*");
    queue_end();
    queue_str("/*");
    queue_end();
    wait_drained();

    target = items_queued + RAND_ITEMS;
    while (items_queued < target) begin
      idle_on = ($urandom_range(0, 3) != 0);
      repeat ($urandom_range(15, 35)) queue_fragment();
      if ($urandom_range(0, 1) == 0) queue_end();
      wait_drained();
    end

    // fill the block while the output is held off
    idle_on  = 1'b1;
    hold_req = 1'b1;
    while (hold_left == 0) @(posedge clk);
    repeat (20) queue_fragment();
    queue_end();
    wait_drained();

    // run of stray closers, no idling
    idle_on = 1'b0;
    repeat (STRAY_CLOSES) queue_str("*/\n");
    queue_str("/*");
    queue_end();
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d text items transferred, %0d results checked, %0d end-of-text reports",
             items_taken, results_seen, end_reports);
    $display("covered strings, line and block comments, stray closers, output hold-off, ",
             "back-to-back tail");
    if (fails == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches", fails);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* filelist.f */
hdl/ccs_pkg.sv
hdl/ccs_scan.sv
hdl/ccs_out_fifo.sv
hdl/c_comment_stripper.sv
hdl/ccs_checker.sv
dv/c_comment_stripper_test.sv
